/* sv/gke_pkg.sv */
`default_nettype none

package gke_pkg;

  localparam int FRAC_BITS         = 16;
  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int SERIES_TERMS      = 24;

  localparam int DATA_W  = 32;
  localparam int IB_W    = 24;
  localparam int MAG_W   = DATA_W + 1;
  localparam int Y_W     = FRAC_BITS + 4;
  localparam int T_W     = FRAC_BITS + 6;
  localparam int U_W     = FRAC_BITS + 6;
  localparam int K_W     = U_W - FRAC_BITS;
  localparam int SH_W    = 5;
  localparam int IDX_W   = $clog2(EXP_TABLE_ENTRIES);
  localparam int LOG2E_W = 31;

  localparam logic [LOG2E_W-1:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [31:0]        LN2_Q32   = 32'd2977044472;
  localparam logic [Y_W-1:0]     Y_LIMIT   = Y_W'(8) << FRAC_BITS;
  localparam logic [K_W-1:0]     K_UNDER   = K_W'(32);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_BW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd2;

  localparam logic [IB_W-1:0]   INV_BW_RESET = 24'd65536;

  typedef logic [31:0] exp_tab_t [EXP_TABLE_ENTRIES];

  // 2^(-i/N) in Q.32, low 32 bits; entry 0 (exactly 1.0) is handled apart
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] z;
    logic [63:0] sum;
    logic [63:0] term;
    logic        done;
    for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
      z    = (64'(i) * 64'(LN2_Q32)) / 64'(EXP_TABLE_ENTRIES);
      sum  = 64'd1 << 32;
      term = 64'd1 << 32;
      done = 1'b0;
      for (int n = 1; n <= SERIES_TERMS; n++) begin
        if (!done) begin
          term = ((term * z + (64'd1 << 31)) >> 32) / 64'(n);
          if (term == 64'd0) begin
            done = 1'b1;
          end else if (n % 2 == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
      tab[i] = sum[31:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

/* sv/gke_dist.sv */
`default_nettype none

module gke_dist (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              up_valid,
  output logic                             up_ready,
  input  wire  [gke_pkg::DATA_W-1:0]       sample,
  input  wire  [gke_pkg::DATA_W-1:0]       center,
  input  wire  [gke_pkg::IB_W-1:0]         inv_bw,
  output logic                             dn_valid,
  input  wire                              dn_ready,
  output logic [gke_pkg::T_W-1:0]          t
);

  localparam int PY_W = gke_pkg::MAG_W + gke_pkg::IB_W;
  localparam int SQ_W = 2 * gke_pkg::Y_W;

  logic [2:0]                    v_r;
  logic [2:0]                    rdy;
  logic [gke_pkg::MAG_W-1:0]     mag_r, mag_nxt;
  logic [gke_pkg::Y_W-1:0]       y_r, y_nxt;
  logic [gke_pkg::T_W-1:0]       t_r, t_nxt;
  logic signed [gke_pkg::MAG_W-1:0] diff;
  logic [PY_W-1:0]               py;
  logic [PY_W-1:0]               py_sh;
  logic [SQ_W-1:0]               sq;

  assign rdy[2]   = !v_r[2] || dn_ready;
  assign rdy[1]   = !v_r[1] || rdy[2];
  assign rdy[0]   = !v_r[0] || rdy[1];
  assign up_ready = rdy[0];
  assign dn_valid = v_r[2];
  assign t        = t_r;

  // distance magnitude
  always_comb begin
    diff    = $signed({sample[gke_pkg::DATA_W-1], sample})
            - $signed({center[gke_pkg::DATA_W-1], center});
    mag_nxt = diff[gke_pkg::MAG_W-1] ? gke_pkg::MAG_W'(-diff) : gke_pkg::MAG_W'(diff);
  end

  // scaled distance, saturated
  always_comb begin
    py    = PY_W'(mag_r) * PY_W'(inv_bw);
    py_sh = py >> (gke_pkg::DATA_W - gke_pkg::FRAC_BITS);
    y_nxt = (py_sh > PY_W'(gke_pkg::Y_LIMIT)) ? gke_pkg::Y_LIMIT : py_sh[gke_pkg::Y_W-1:0];
  end

  // half square
  always_comb begin
    sq    = SQ_W'(y_r) * SQ_W'(y_r);
    t_nxt = gke_pkg::T_W'(sq >> (gke_pkg::FRAC_BITS + 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 3'b000;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && up_valid) mag_r <= mag_nxt;
    if (rdy[1] && v_r[0])   y_r   <= y_nxt;
    if (rdy[2] && v_r[1])   t_r   <= t_nxt;
  end

  a_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> y_r <= gke_pkg::Y_LIMIT)
    else $error("scaled distance above saturation limit");

  a_t_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] && !dn_ready |=> v_r[2] && $stable(t_r))
    else $error("half square lost while stalled");

endmodule

`default_nettype wire

/* sv/gke_exp.sv */
`default_nettype none

module gke_exp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              up_valid,
  output logic                             up_ready,
  input  wire  [gke_pkg::T_W-1:0]          t,
  input  wire  [gke_pkg::DATA_W-1:0]       scale,
  output logic                             dn_valid,
  input  wire                              dn_ready,
  output logic [gke_pkg::DATA_W-1:0]       density
);

  localparam int LP_W   = gke_pkg::T_W + gke_pkg::LOG2E_W;
  localparam int IP_W   = gke_pkg::FRAC_BITS + gke_pkg::IDX_W + 1;
  localparam int IR_W   = gke_pkg::IDX_W + 1;
  localparam int PR_W   = 2 * gke_pkg::DATA_W;

  logic [3:0]                        v_r;
  logic [3:0]                        rdy;

  logic [LP_W-1:0]                   lp;
  logic [gke_pkg::U_W-1:0]           u;
  logic [gke_pkg::K_W-1:0]           k;
  logic [IP_W-1:0]                   ip;
  logic [IR_W-1:0]                   idx_raw;
  logic [gke_pkg::IDX_W-1:0]         idx_nxt;
  logic                              under_nxt;

  logic                              under0_r, under1_r, under2_r;
  logic [gke_pkg::SH_W-1:0]          k0_r, k1_r, k2_r;
  logic [gke_pkg::IDX_W-1:0]         idx_r;
  logic [gke_pkg::DATA_W-1:0]        tab_r, tab_nxt;
  logic                              full_r;
  logic [PR_W-1:0]                   prod;
  logic [gke_pkg::DATA_W-1:0]        hi_r, hi_nxt;
  logic [gke_pkg::DATA_W-1:0]        dens_r, dens_nxt;

  assign rdy[3]   = !v_r[3] || dn_ready;
  assign rdy[2]   = !v_r[2] || rdy[3];
  assign rdy[1]   = !v_r[1] || rdy[2];
  assign rdy[0]   = !v_r[0] || rdy[1];
  assign up_ready = rdy[0];
  assign dn_valid = v_r[3];
  assign density  = dens_r;

  // exponent in base 2, split into shift and table index
  always_comb begin
    lp        = LP_W'(t) * LP_W'(gke_pkg::LOG2E_Q30);
    u         = gke_pkg::U_W'(lp >> 30);
    k         = u[gke_pkg::U_W-1:gke_pkg::FRAC_BITS];
    under_nxt = (k >= gke_pkg::K_UNDER);
    ip        = IP_W'(u[gke_pkg::FRAC_BITS-1:0]) * IP_W'(gke_pkg::EXP_TABLE_ENTRIES);
    idx_raw   = IR_W'(ip >> gke_pkg::FRAC_BITS);
    idx_nxt   = (idx_raw >= IR_W'(gke_pkg::EXP_TABLE_ENTRIES)) ?
                gke_pkg::IDX_W'(gke_pkg::EXP_TABLE_ENTRIES - 1) :
                idx_raw[gke_pkg::IDX_W-1:0];
  end

  assign tab_nxt = gke_pkg::EXP_TAB[idx_r];

  always_comb begin
    prod   = PR_W'(scale) * PR_W'(tab_r);
    hi_nxt = full_r ? scale : prod[PR_W-1:gke_pkg::DATA_W];
  end

  assign dens_nxt = under2_r ? '0 : (hi_r >> k2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 4'b0000;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && up_valid) begin
      under0_r <= under_nxt;
      k0_r     <= k[gke_pkg::SH_W-1:0];
      idx_r    <= idx_nxt;
    end
    if (rdy[1] && v_r[0]) begin
      under1_r <= under0_r;
      k1_r     <= k0_r;
      tab_r    <= tab_nxt;
      full_r   <= (idx_r == '0);
    end
    if (rdy[2] && v_r[1]) begin
      under2_r <= under1_r;
      k2_r     <= k1_r;
      hi_r     <= hi_nxt;
    end
    if (rdy[3] && v_r[2]) begin
      dens_r   <= dens_nxt;
    end
  end

  a_tab_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] && !full_r |-> tab_r[gke_pkg::DATA_W-1])
    else $error("table entry below one half");

  a_dens_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] && !dn_ready |=> v_r[3] && $stable(dens_r))
    else $error("result lost while stalled");

endmodule

`default_nettype wire

/* sv/gaussian_kernel_eval_unit.sv */
// channel   direction  handshake             payload
// in_       input      in_valid / in_stall   in_sample     signed Q16.16
// out_      output     out_valid / out_stall out_density   unsigned Q0.32
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one sample per cycle sustained while out_stall is low
// seven-stage datapath: three distance stages, four exponent stages
// rst_n is synchronous: clears stage valids and loads register defaults
// each stage advances when the next is empty or advancing, so bubbles close under stall
// cfg_ready is always high; registers are read live by the datapath
`default_nettype none

module gaussian_kernel_eval_unit (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [gke_pkg::DATA_W-1:0]           in_sample,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [gke_pkg::DATA_W-1:0]           out_density,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [gke_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [gke_pkg::DATA_W-1:0]           cfg_data
);

  logic [gke_pkg::DATA_W-1:0] center_r;
  logic [gke_pkg::IB_W-1:0]   inv_bw_r;
  logic [gke_pkg::DATA_W-1:0] scale_r;

  logic                       dist_ready;
  logic                       mid_valid;
  logic                       mid_ready;
  logic [gke_pkg::T_W-1:0]    mid_t;

  assign cfg_ready = 1'b1;
  assign in_stall  = !dist_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0;
      inv_bw_r <= gke_pkg::INV_BW_RESET;
      scale_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gke_pkg::REG_CENTER: center_r <= cfg_data;
        gke_pkg::REG_INV_BW: inv_bw_r <= cfg_data[gke_pkg::IB_W-1:0];
        gke_pkg::REG_SCALE:  scale_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gke_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (dist_ready),
    .sample   (in_sample),
    .center   (center_r),
    .inv_bw   (inv_bw_r),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .t        (mid_t)
  );

  gke_exp u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .t        (mid_t),
    .scale    (scale_r),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .density  (out_density)
  );

  a_zero_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && scale_r == '0 |-> out_density == '0)
    else $error("nonzero density with zero scale");

  a_no_overtake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && scale_r != '0 |-> out_density <= scale_r)
    else $error("density above scale");

endmodule

`default_nettype wire
